// ----- hw/rtl/mu8d_pkg.sv -----
package mu8d_pkg;

	typedef enum logic [1:0] {
		PH_HDR_HI,
		PH_HDR_LO,
		PH_BODY,
		PH_SKIP
	} phase_t;

	localparam logic [2:0] ST_CHAR     = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_PARTIAL  = 3'd2;
	localparam logic [2:0] ST_BAD_CONT = 3'd3;
	localparam logic [2:0] ST_BAD_LEAD = 3'd4;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  length_high;
		logic [15:0] bytes_left;
		logic [1:0]  conts_wanted;
		logic [15:0] partial_value;
	} dec_state_t;

	typedef struct packed {
		logic        emit;
		logic [15:0] code_unit;
		logic [2:0]  status;
		logic        last;
	} dec_result_t;

endpackage

// ----- hw/rtl/mu8d_step.sv -----
module mu8d_step (
	input  mu8d_pkg::dec_state_t  cur,
	input  logic [7:0]            byte_in,
	output mu8d_pkg::dec_state_t  nxt,
	output mu8d_pkg::dec_result_t res
);

	logic [15:0] remaining;
	logic [15:0] pv_shift;
	logic [1:0]  cw_dec;
	logic        fail;
	logic [2:0]  fail_status;

	assign remaining = cur.bytes_left - 16'd1;
	assign pv_shift  = {cur.partial_value[9:0], byte_in[5:0]};
	assign cw_dec    = cur.conts_wanted - 2'd1;

	always_comb begin
		nxt         = cur;
		res         = '0;
		res.status  = mu8d_pkg::ST_CHAR;
		fail        = 1'b0;
		fail_status = mu8d_pkg::ST_CHAR;
		case (cur.phase)
			mu8d_pkg::PH_HDR_HI: begin
				nxt.length_high = byte_in;
				nxt.phase       = mu8d_pkg::PH_HDR_LO;
			end
			mu8d_pkg::PH_HDR_LO: begin
				nxt.bytes_left    = {cur.length_high, byte_in};
				nxt.conts_wanted  = 2'd0;
				nxt.partial_value = 16'd0;
				if ({cur.length_high, byte_in} == 16'd0) begin
					nxt.phase  = mu8d_pkg::PH_HDR_HI;
					res.emit   = 1'b1;
					res.status = mu8d_pkg::ST_EMPTY;
					res.last   = 1'b1;
				end else begin
					nxt.phase = mu8d_pkg::PH_BODY;
				end
			end
			mu8d_pkg::PH_SKIP: begin
				nxt.bytes_left = remaining;
				if (remaining == 16'd0) begin
					nxt.phase = mu8d_pkg::PH_HDR_HI;
				end
			end
			mu8d_pkg::PH_BODY: begin
				if (cur.conts_wanted == 2'd0) begin
					if (!byte_in[7]) begin
						nxt.bytes_left = remaining;
						if (remaining == 16'd0) begin
							nxt.phase = mu8d_pkg::PH_HDR_HI;
						end
						res.emit      = 1'b1;
						res.code_unit = {8'd0, byte_in};
						res.last      = (remaining == 16'd0);
					end else if (byte_in[7:5] == 3'b110) begin
						if (remaining == 16'd0) begin
							fail        = 1'b1;
							fail_status = mu8d_pkg::ST_PARTIAL;
						end else begin
							nxt.partial_value = {11'd0, byte_in[4:0]};
							nxt.conts_wanted  = 2'd1;
							nxt.bytes_left    = remaining;
						end
					end else if (byte_in[7:4] == 4'b1110) begin
						if (remaining < 16'd2) begin
							fail        = 1'b1;
							fail_status = mu8d_pkg::ST_PARTIAL;
						end else begin
							nxt.partial_value = {12'd0, byte_in[3:0]};
							nxt.conts_wanted  = 2'd2;
							nxt.bytes_left    = remaining;
						end
					end else begin
						fail        = 1'b1;
						fail_status = mu8d_pkg::ST_BAD_LEAD;
					end
				end else if (byte_in[7:6] != 2'b10) begin
					fail        = 1'b1;
					fail_status = mu8d_pkg::ST_BAD_CONT;
				end else begin
					nxt.partial_value = pv_shift;
					nxt.conts_wanted  = cw_dec;
					nxt.bytes_left    = remaining;
					if (cw_dec == 2'd0) begin
						if (remaining == 16'd0) begin
							nxt.phase = mu8d_pkg::PH_HDR_HI;
						end
						res.emit          = 1'b1;
						res.code_unit     = pv_shift;
						res.last          = (remaining == 16'd0);
						nxt.partial_value = 16'd0;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
		// error: report, then drop the rest of the string body
		if (fail) begin
			res.emit          = 1'b1;
			res.code_unit     = 16'd0;
			res.status        = fail_status;
			res.last          = 1'b1;
			nxt.conts_wanted  = 2'd0;
			nxt.partial_value = 16'd0;
			nxt.bytes_left    = remaining;
			nxt.phase         = (remaining == 16'd0) ? mu8d_pkg::PH_HDR_HI
				: mu8d_pkg::PH_SKIP;
		end
	end

endmodule

// ----- hw/rtl/modified_utf8_decoder_unit.sv -----
// a result reaches the result register once its final byte has passed the input register
// throughput: one byte per clock, sustained while out_ready stays high
// an input register and a result register bound a single decode pass
// reset (arst_n low, asynchronous) empties both registers and returns the
// decoder to waiting for the high byte of a string header
module modified_utf8_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic [2:0]  status,
	output logic        last
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  adv_s1;
	mu8d_pkg::dec_state_t  state_q;
	mu8d_pkg::dec_state_t  state_next;
	mu8d_pkg::dec_result_t res;
	logic                  out_valid_q;
	logic [15:0]           code_unit_q;
	logic [2:0]            status_q;
	logic                  last_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
		end
	end

	mu8d_step u_step (
		.cur     (state_q),
		.byte_in (byte_s1),
		.nxt     (state_next),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{phase: mu8d_pkg::PH_HDR_HI, default: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_next;
			end
			if (adv_s1) begin
				out_valid_q <= res.emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && res.emit) begin
			code_unit_q <= res.code_unit;
			status_q    <= res.status;
			last_q      <= res.last;
		end
	end

	assign out_valid = out_valid_q;
	assign code_unit = code_unit_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

// ----- test/modified_utf8_decoder_unit_tb.sv -----
module modified_utf8_decoder_unit_tb;

	localparam int CLK_HALF     = 6;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_BYTES  = 490;
	localparam int SETTLE_CYCLES = 10;

	typedef struct {
		logic [15:0] cu;
		logic [2:0]  st;
		logic        lst;
	} unit_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  byte_in;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] code_unit;
	logic [2:0]  status;
	logic        last;

	modified_utf8_decoder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.byte_in   (byte_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.code_unit (code_unit),
		.status    (status),
		.last      (last)
	);

	logic [7:0]   stream_q[$];
	logic [7:0]   body_q[$];
	unit_result_t unit_q[$];
	unit_result_t got_unit;

	// decoder state mirrored in the testbench
	mu8d_pkg::phase_t dec_phase;
	logic [7:0]  dec_len_hi;
	logic [15:0] dec_left;
	logic [1:0]  dec_conts;
	logic [15:0] dec_acc;

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_req;
	int hold_ack;
	int hold_cnt;
	int cycle_cnt;
	int n_queued;
	int n_sent;
	int n_checked;
	int n_chars;
	int n_empty;
	int n_errors;
	int n_err;

	function automatic void post_unit(logic [15:0] cu, logic [2:0] st, logic lst);
		unit_result_t r;
		r.cu  = cu;
		r.st  = st;
		r.lst = lst;
		unit_q.push_back(r);
	endfunction

	function automatic void abort_string(logic [2:0] st, logic [15:0] rem);
		post_unit(16'h0000, st, 1'b1);
		dec_conts = 2'd0;
		dec_acc   = 16'h0000;
		dec_left  = rem;
		dec_phase = (rem == 16'h0000) ? mu8d_pkg::PH_HDR_HI : mu8d_pkg::PH_SKIP;
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		logic [15:0] rem;
		rem = dec_left - 16'd1;
		case (dec_phase)
			mu8d_pkg::PH_HDR_HI: begin
				dec_len_hi = b;
				dec_phase  = mu8d_pkg::PH_HDR_LO;
			end
			mu8d_pkg::PH_HDR_LO: begin
				dec_left  = {dec_len_hi, b};
				dec_conts = 2'd0;
				dec_acc   = 16'h0000;
				if (dec_left == 16'h0000) begin
					dec_phase = mu8d_pkg::PH_HDR_HI;
					post_unit(16'h0000, mu8d_pkg::ST_EMPTY, 1'b1);
				end else begin
					dec_phase = mu8d_pkg::PH_BODY;
				end
			end
			mu8d_pkg::PH_SKIP: begin
				dec_left = rem;
				if (rem == 16'h0000)
					dec_phase = mu8d_pkg::PH_HDR_HI;
			end
			default: begin
				if (dec_conts == 2'd0) begin
					if (b[7] == 1'b0) begin
						dec_left = rem;
						if (rem == 16'h0000)
							dec_phase = mu8d_pkg::PH_HDR_HI;
						post_unit({8'h00, b}, mu8d_pkg::ST_CHAR, rem == 16'h0000);
					end else if (b[7:5] == 3'b110) begin
						if (rem < 16'd1) begin
							abort_string(mu8d_pkg::ST_PARTIAL, rem);
						end else begin
							dec_acc   = {11'h000, b[4:0]};
							dec_conts = 2'd1;
							dec_left  = rem;
						end
					end else if (b[7:4] == 4'b1110) begin
						if (rem < 16'd2) begin
							abort_string(mu8d_pkg::ST_PARTIAL, rem);
						end else begin
							dec_acc   = {12'h000, b[3:0]};
							dec_conts = 2'd2;
							dec_left  = rem;
						end
					end else begin
						abort_string(mu8d_pkg::ST_BAD_LEAD, rem);
					end
				end else if (b[7:6] != 2'b10) begin
					abort_string(mu8d_pkg::ST_BAD_CONT, rem);
				end else begin
					dec_acc   = {dec_acc[9:0], b[5:0]};
					dec_conts = dec_conts - 2'd1;
					dec_left  = rem;
					if (dec_conts == 2'd0) begin
						if (rem == 16'h0000)
							dec_phase = mu8d_pkg::PH_HDR_HI;
						post_unit(dec_acc, mu8d_pkg::ST_CHAR, rem == 16'h0000);
						dec_acc = 16'h0000;
					end
				end
			end
		endcase
	endfunction

	// header from the body length, then the body
	function automatic void send_string();
		int n;
		n = body_q.size();
		stream_q.push_back(n[15:8]);
		stream_q.push_back(n[7:0]);
		foreach (body_q[i])
			stream_q.push_back(body_q[i]);
		body_q.delete();
		n_queued += n + 2;
	endfunction

	function automatic void push_char();
		logic [7:0] r0;
		logic [7:0] r1;
		logic [7:0] r2;
		r0 = 8'($urandom);
		r1 = 8'($urandom);
		r2 = 8'($urandom);
		case ($urandom_range(2))
			0: body_q.push_back({1'b0, r0[6:0]});
			1: begin
				body_q.push_back({3'b110, r0[4:0]});
				body_q.push_back({2'b10, r1[5:0]});
			end
			default: begin
				body_q.push_back({4'b1110, r0[3:0]});
				body_q.push_back({2'b10, r1[5:0]});
				body_q.push_back({2'b10, r2[5:0]});
			end
		endcase
	endfunction

	function automatic void add_random_string();
		int kind;
		int target;
		logic [7:0] r0;
		logic [7:0] r1;
		kind = $urandom_range(99);
		r0 = 8'($urandom);
		r1 = 8'($urandom);
		if ($urandom_range(49) == 0)
			target = $urandom_range(256, 400);
		else
			target = $urandom_range(1, 24);
		if (kind >= 5 && kind < 15) begin
			repeat (target) body_q.push_back(8'($urandom));
		end else if (kind >= 15) begin
			while (body_q.size() < target)
				push_char();
			if (kind < 35) begin
				case ($urandom_range(2))
					0: body_q[$urandom_range(body_q.size() - 1)] = r0;
					1: body_q.push_back({3'b110, r0[4:0]});
					default: begin
						body_q.push_back({4'b1110, r0[3:0]});
						body_q.push_back({2'b10, r1[5:0]});
					end
				endcase
			end
		end
		send_string();
	endfunction

	function automatic void add_directed();
		send_string();
		body_q = '{8'h00, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80,
			8'hEF, 8'hBF, 8'hBF, 8'h7F};
		send_string();
		body_q = '{8'hC2};
		send_string();
		body_q = '{8'hE0, 8'h80};
		send_string();
		body_q = '{8'hC2, 8'h41};
		send_string();
		body_q = '{8'h80};
		send_string();
		body_q = '{8'hF5};
		send_string();
	endfunction

	always #CLK_HALF clk = ~clk;

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	// sender
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			decode_byte(byte_in);
			n_sent++;
		end
		if (!in_valid || in_ready) begin
			if (arst_n && stream_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				byte_in  <= stream_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver ready, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_cnt  <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// result check
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (unit_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected transfer: code_unit %h status %0d last %0b",
						code_unit, status, last);
			end else begin
				got_unit = unit_q.pop_front();
				n_checked++;
				if (got_unit.st == mu8d_pkg::ST_CHAR)
					n_chars++;
				else if (got_unit.st == mu8d_pkg::ST_EMPTY)
					n_empty++;
				else
					n_errors++;
				if (code_unit !== got_unit.cu || status !== got_unit.st ||
						last !== got_unit.lst) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: code_unit %h/%h status %0d/%0d last %0b/%0b (exp/got)",
							got_unit.cu, code_unit, got_unit.st, status, got_unit.lst, last);
				end
			end
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_cnt);
		$display("FAIL modified_utf8_decoder_unit");
		$finish;
	end

	initial begin
		int budget;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		byte_in      = 8'h00;
		out_ready    = 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req     = 0;
		hold_ack     = 0;
		hold_cnt     = 0;
		cycle_cnt    = 0;
		n_queued     = 0;
		n_sent       = 0;
		n_checked    = 0;
		n_chars      = 0;
		n_empty      = 0;
		n_errors     = 0;
		n_err        = 0;
		dec_phase    = mu8d_pkg::PH_HDR_HI;
		dec_len_hi   = 8'h00;
		dec_left     = 16'h0000;
		dec_conts    = 2'd0;
		dec_acc      = 16'h0000;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
				default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
			endcase
			budget = n_queued + PHASE_BYTES;
			if (ph == 0) begin
				hold_req++;
				add_directed();
			end
			while (n_queued < budget)
				add_random_string();
			while (stream_q.size() != 0 || in_valid)
				@(negedge clk);
			while (unit_q.size() != 0)
				@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		n_err += unit_q.size();
		$display("%0d bytes decoded, %0d results checked: %0d chars, %0d empty, %0d errors",
			n_sent, n_checked, n_chars, n_empty, n_errors);
		$display("four idle/stall mixes, one %0d-cycle receiver hold-off, %0d mismatches",
			HOLD_CYCLES, n_err);
		if (n_err == 0)
			$display("PASS modified_utf8_decoder_unit");
		else
			$display("FAIL modified_utf8_decoder_unit");
		$finish;
	end

endmodule
